[hw/rtl/sfsp_pkg.sv]
`timescale 1ns / 1ps
package sfsp_pkg;

   localparam int GuidBytes = 16;
   localparam int DescriptionBytes = 240;

   localparam logic [31:0] CrcPoly = 32'hEDB88320;
   localparam logic [31:0] MagicWord = 32'h41444355;
   localparam logic [31:0] MarkWord = 32'h41544144;
   localparam logic [11:0] VersionReset = 12'd5;

   localparam logic [2:0] KIND_FILE = 3'd0;
   localparam logic [2:0] KIND_SCAN = 3'd1;
   localparam logic [2:0] KIND_READ = 3'd2;
   localparam logic [2:0] KIND_FLAG = 3'd3;
   localparam logic [2:0] KIND_DONE = 3'd4;
   localparam logic [2:0] KIND_ERROR = 3'd5;

   localparam logic [1:0] ERR_NOT_DATA = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_TYPE = 2'd2;
   localparam logic [1:0] ERR_CRC = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  item_kind;
      logic [3:0]  field_index;
      logic [31:0] field_value;
      logic [15:0] value_code;
      logic [15:0] std_code;
      logic        std_present;
      logic [14:0] scan_number;
      logic [30:0] reading_index;
      logic [1:0]  error_code;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      end
      return r;
   endfunction

endpackage

[hw/rtl/scan_file_stream_parser.sv]
`timescale 1ns / 1ps
// Scan-data file stream parser.
// req_ channel: one file byte per request, file_start marks the first byte of a
//   file and restarts the parse. A request is accepted when req_valid is high
//   and req_stall is low.
// rsp_ channel: zero or one result per request (header fields, readings, flag
//   bytes, done or error). Taken when rsp_valid is high and rsp_stall is low.
// csr_ channel: writes expected_version (valid/ready); ready is always high.
// A result is registered and appears in the cycle after the byte that completes it.
// Throughput: one byte per cycle while req_stall is low, set by the bytewise
//   CRC update and field decode, done combinationally before the result register.
// The result register is a one-entry buffer: while it holds a result and the
//   receiver stalls, req_stall is raised, so no request is lost; when the
//   result is taken in the same cycle a new request is accepted.
// Reset: synchronous; the parser idles waiting for file_start, the CRC is all
//   ones, expected_version returns to 5 and no result is pending.
// After an error or a finished file the parser ignores bytes until the next
//   file_start.
module scan_file_stream_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sfsp_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sfsp_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [11:0]         csr_data
);
   import sfsp_pkg::*;

   typedef enum logic [4:0] {
      P_IDLE = 5'd0, P_MAGIC = 5'd1, P_VER = 5'd2, P_TYPE = 5'd3, P_GUID = 5'd4,
      P_DESC = 5'd5, P_FILE = 5'd6, P_MARK = 5'd14, P_SCAN = 5'd15,
      P_READ = 5'd22, P_FLAG = 5'd23, P_CRC = 5'd24
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] crc_ff, crc_in;
   logic [14:0] scans_left_ff, scans_left_in;
   logic [14:0] cur_scan_ff, cur_scan_in;
   logic [30:0] reads_left_ff, reads_left_in;
   logic [30:0] cur_read_ff, cur_read_in;
   logic [27:0] flags_left_ff, flags_left_in;
   logic        std_ff, std_in;
   logic [15:0] held_ff, held_in;
   logic [11:0] version_ff;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic        accept;
   assign req_stall = out_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      phase_type   p;
      logic [7:0]  b, cnt, plen;
      logic [31:0] w;
      logic [3:0]  idx;
      logic [11:0] v;
      logic        emit;
      logic [2:0]  kind;
      logic [3:0]  fidx;
      logic [31:0] fval;
      logic [15:0] vcode, scode;
      logic [1:0]  ecode;
      logic [30:0] n;
      logic [14:0] sl;
      phase_in = phase_ff;  count_in = count_ff;  word_in = word_ff;  crc_in = crc_ff;
      scans_left_in = scans_left_ff;  cur_scan_in = cur_scan_ff;
      reads_left_in = reads_left_ff;  cur_read_in = cur_read_ff;
      flags_left_in = flags_left_ff;  std_in = std_ff;  held_in = held_ff;
      emit = 1'b0;  kind = KIND_FILE;  fidx = 4'd0;  fval = 32'd0;
      vcode = 16'd0;  scode = 16'd0;  ecode = ERR_NOT_DATA;
      b = req_data.data_byte;  w = 32'd0;  idx = 4'd0;  v = 12'd0;  n = 31'd0;
      sl = 15'd0;  plen = 8'd1;  cnt = 8'd0;
      p = phase_ff;
      // Restart the parse on a file start.
      if (req_data.file_start) begin
         p = P_MAGIC;  count_in = 8'd0;  word_in = 32'd0;  crc_in = 32'hFFFFFFFF;
         scans_left_in = 15'd0;  cur_scan_in = 15'd0;  reads_left_in = 31'd0;
         cur_read_in = 31'd0;  flags_left_in = 28'd0;  std_in = 1'b0;
         held_in = 16'd0;
      end
      phase_in = p;
      if (p != P_IDLE) begin
         if (p != P_CRC) crc_in = crc_byte(crc_in, b);
         cnt = count_in;
         w = word_in;
         case (cnt)
            8'd0: w[7:0] = w[7:0] | b;
            8'd1: w[15:8] = w[15:8] | b;
            8'd2: w[23:16] = w[23:16] | b;
            8'd3: w[31:24] = w[31:24] | b;
            default: ;
         endcase
         cnt = cnt + 8'd1;
         if (p == P_READ && cnt == 8'd2) held_in = w[15:0];
         case (p)
            P_MAGIC, P_MARK, P_CRC: plen = 8'd4;
            P_VER, P_TYPE: plen = 8'd2;
            P_GUID: plen = 8'(GuidBytes);
            P_DESC: plen = 8'(DescriptionBytes);
            P_FILE, 5'd7, 5'd13: plen = 8'd2;
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12: plen = 8'd4;
            5'd19: plen = 8'd2;
            P_SCAN, 5'd16, 5'd17, 5'd18, 5'd20, 5'd21: plen = 8'd4;
            P_READ: plen = std_in ? 8'd4 : 8'd2;
            default: plen = 8'd1;
         endcase
         count_in = cnt;
         word_in = w;
         if (cnt >= plen) begin
            count_in = 8'd0;
            word_in = 32'd0;
            emit = 1'b1;
            if (p == P_MAGIC || p == P_MARK) begin
               if (w != (p == P_MAGIC ? MagicWord : MarkWord)) begin
                  kind = KIND_ERROR;  ecode = ERR_NOT_DATA;  phase_in = P_IDLE;
               end else begin
                  emit = 1'b0;
                  phase_in = (p == P_MAGIC) ? P_VER : P_SCAN;
               end
            end else if (p == P_VER) begin
               v = {w[3:0], 4'd0, w[11:8]};
               if (v != version_ff) begin
                  kind = KIND_ERROR;  ecode = ERR_VERSION;  phase_in = P_IDLE;
               end else begin
                  emit = 1'b0;  phase_in = P_TYPE;
               end
            end else if (p == P_TYPE) begin
               phase_in = P_GUID;
               case (w[15:0])
                  16'h4152: fval = 32'd0;
                  16'h5049: fval = 32'd1;
                  16'h4952: fval = 32'd2;
                  16'h4946: fval = 32'd3;
                  16'h4157: fval = 32'd4;
                  16'h4957: fval = 32'd5;
                  default: begin
                     kind = KIND_ERROR;  ecode = ERR_TYPE;  phase_in = P_IDLE;
                  end
               endcase
            end else if (p == P_GUID) begin
               emit = 1'b0;  phase_in = P_DESC;
            end else if (p == P_DESC) begin
               emit = 1'b0;  phase_in = P_FILE;
            end else if (p >= P_FILE && p < P_MARK) begin
               idx = 4'(p - P_FILE + 5'd1);
               kind = KIND_FILE;  fidx = idx;  fval = w;
               if ((idx == 4'd6 || idx == 4'd7) && w[30:0] != 31'd0) std_in = 1'b1;
               if (idx == 4'd8) begin
                  sl = w[15] ? 15'd0 : w[14:0];
                  scans_left_in = sl;
                  cur_scan_in = 15'd0;
                  phase_in = (sl != 15'd0) ? P_MARK : P_CRC;
               end else begin
                  phase_in = phase_type'(p + 5'd1);
               end
            end else if (p >= P_SCAN && p < P_READ) begin
               idx = 4'(p - P_SCAN);
               kind = KIND_SCAN;  fidx = idx;  fval = w;
               if (idx == 4'd6) begin
                  n = w[31] ? 31'd0 : w[30:0];
                  reads_left_in = n;
                  cur_read_in = 31'd0;
                  flags_left_in = 28'(({1'b0, n} + 32'd7) >> 3);
                  if (n != 31'd0) phase_in = P_READ;
                  else begin
                     scans_left_in = scans_left_ff - 15'd1;
                     cur_scan_in = cur_scan_ff + 15'd1;
                     phase_in = (scans_left_in != 15'd0) ? P_MARK : P_CRC;
                  end
               end else begin
                  phase_in = phase_type'(p + 5'd1);
               end
            end else if (p == P_READ) begin
               kind = KIND_READ;  vcode = held_in;
               scode = std_in ? w[31:16] : 16'd0;
               cur_read_in = cur_read_ff + 31'd1;
               reads_left_in = reads_left_ff - 31'd1;
               // Any nonzero reading count leaves flag bytes; a full-range count
               // wraps the flag counter to zero, which then runs all 2^28 bytes.
               if (reads_left_in == 31'd0) begin
                  cur_read_in = 31'd0;
                  phase_in = P_FLAG;
               end
            end else if (p == P_FLAG) begin
               kind = KIND_FLAG;  fval = {24'd0, b};
               cur_read_in = cur_read_ff + 31'd1;
               flags_left_in = flags_left_ff - 28'd1;
               if (flags_left_in == 28'd0) begin
                  scans_left_in = scans_left_ff - 15'd1;
                  cur_scan_in = cur_scan_ff + 15'd1;
                  phase_in = (scans_left_in != 15'd0) ? P_MARK : P_CRC;
               end
            end else begin
               // Trailing CRC: compare against the running value.
               phase_in = P_IDLE;
               if (w != crc_in) begin
                  kind = KIND_ERROR;  ecode = ERR_CRC;
               end else begin
                  kind = KIND_DONE;
               end
            end
         end
      end
      out_in.item_kind = kind;
      out_in.field_index = (kind == KIND_FILE || kind == KIND_SCAN) ? fidx : 4'd0;
      out_in.field_value = (kind <= KIND_FLAG && kind != KIND_READ) ? fval : 32'd0;
      out_in.value_code = vcode;
      out_in.std_code = scode;
      out_in.std_present = std_in;
      out_in.scan_number = (kind == KIND_SCAN || kind == KIND_READ || kind == KIND_FLAG)
                           ? cur_scan_ff : 15'd0;
      out_in.reading_index = (kind == KIND_READ || kind == KIND_FLAG) ? cur_read_ff : 31'd0;
      out_in.error_code = (kind == KIND_ERROR) ? ecode : 2'd0;
      out_valid_in = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         count_ff <= 8'd0;
         word_ff <= 32'd0;
         crc_ff <= 32'hFFFFFFFF;
         scans_left_ff <= 15'd0;
         cur_scan_ff <= 15'd0;
         reads_left_ff <= 31'd0;
         cur_read_ff <= 31'd0;
         flags_left_ff <= 28'd0;
         std_ff <= 1'b0;
         held_ff <= 16'd0;
         version_ff <= VersionReset;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) version_ff <= csr_data;
         // Drop a result once taken; load the next one, if any, with each accepted request.
         if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            word_ff <= word_in;
            crc_ff <= crc_in;
            scans_left_ff <= scans_left_in;
            cur_scan_ff <= cur_scan_in;
            reads_left_ff <= reads_left_in;
            cur_read_ff <= cur_read_in;
            flags_left_ff <= flags_left_in;
            std_ff <= std_in;
            held_ff <= held_in;
            out_valid_ff <= out_valid_in;
            if (out_valid_in) out_ff <= out_in;
         end
      end
   end
endmodule
